// ===== hdl/dbr_pkg.sv =====
// dbr_pkg: shared types and constants for the dense bitmap next-set-bit/rank block
// no dependencies
`timescale 1ns / 1ps

package dbr_pkg;

  localparam int BlockWords = 1024;
  localparam int WordBits   = 64;
  localparam int SpanBits   = 512;
  localparam int SpanWords  = SpanBits / WordBits;
  localparam int SpanCount  = BlockWords / SpanWords;
  localparam int WAddrW     = $clog2(BlockWords);
  localparam int SAddrW     = $clog2(SpanCount);
  localparam int SubW       = $clog2(SpanWords);
  localparam int BitW       = $clog2(WordBits);
  localparam int PopW       = BitW + 1;

  typedef enum logic [1:0] {
    REQ_RESTART = 2'd0,
    REQ_LOAD    = 2'd1,
    REQ_SEEK    = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [0:0] {
    CFG_BLOCK_ID  = 1'b0,
    CFG_RANK_BASE = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RANK_SPAN,
    ST_RANK_WORDS,
    ST_OUT
  } state_e;

  // population count of one word
  function automatic logic [PopW-1:0] pop_word(input logic [WordBits-1:0] v);
    logic [PopW-1:0] n;
    n = '0;
    for (int i = 0; i < WordBits; i++) n = n + PopW'(v[i]);
    return n;
  endfunction

  // index of lowest set bit (v nonzero)
  function automatic logic [BitW-1:0] low_zeros(input logic [WordBits-1:0] v);
    logic [BitW-1:0] n;
    n = '0;
    for (int i = WordBits - 1; i >= 0; i--) if (v[i]) n = BitW'(i);
    return n;
  endfunction

endpackage

// ===== hdl/dbr_word_ram.sv =====
// dbr_word_ram: bitmap word store, one write and one registered read port
// depends on dbr_pkg
`timescale 1ns / 1ps

module dbr_word_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [dbr_pkg::WAddrW-1:0]   waddr_i,
  input  logic [dbr_pkg::WordBits-1:0] wdata_i,
  input  logic [dbr_pkg::WAddrW-1:0]   raddr_i,
  output logic [dbr_pkg::WordBits-1:0] rdata_o
);
  import dbr_pkg::*;

  logic [WordBits-1:0] mem_q [BlockWords];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/dense_bitmap_next_set_bit_rank.sv =====
// Dense bitmap block: next set bit at or after a target, with its rank.
// Restart, load and unknown requests: result valid the cycle after acceptance; one item
// in flight, so no new request is taken until the last result is accepted. A seek scans
// one word per cycle, then reads the span prefix and, each after its own read wait, the
// words of the hit's 512-bit span up to the hit word; a miss ends at the last loaded
// word, and a target past the loaded words misses without a scan. Reset clears the
// load pointer, load count, cursor and config registers; the memories are not cleared
// and are only used where loaded since the last restart.
`timescale 1ns / 1ps

module dense_bitmap_next_set_bit_rank (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // word_data[63:0], target[79:64]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // doc_id[31:0], rank[63:32]
  output logic        m_axis_tuser,   // found
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import dbr_pkg::*;

  state_e state_q, state_d;
  logic [15:0] block_id_q;
  logic [31:0] rank_base_q;
  logic [WAddrW:0] lp_q;
  logic [16:0] run_q;
  logic [15:0] last_q;
  logic last_v_q;
  logic [15:0] tgt_q;
  logic [WAddrW-1:0] wi_q;
  logic first_q, rd_pend_q;
  logic [15:0] pos_q;
  logic [16:0] cnt_q;
  logic [SubW-1:0] rk_q;
  logic found_q;
  logic [31:0] out_doc_q, out_rank_q;
  logic out_v_q;
  logic [15:0] span_q [SpanCount];
  logic [15:0] span_rd_q;

  logic acc;
  req_e req;
  logic [15:0] tgt_in;
  logic [WordBits-1:0] wdata_in, rdata;
  logic ram_we;
  logic [WAddrW-1:0] raddr;
  logic [WordBits-1:0] masked;
  logic [WAddrW:0] limit;

  assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign req      = req_e'(s_axis_tuser);
  assign tgt_in   = s_axis_tdata[79:64];
  assign wdata_in = s_axis_tdata[63:0];
  assign cfg_ready_o = 1'b1;
  assign limit = lp_q;
  assign ram_we = acc && req == REQ_LOAD && lp_q < (WAddrW+1)'(BlockWords);

  dbr_word_ram u_ram (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(lp_q[WAddrW-1:0]), .wdata_i(wdata_in),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // span prefix table, registered read
  always_ff @(posedge clk_i) begin
    if (ram_we && lp_q[SubW-1:0] == '0) span_q[lp_q[WAddrW-1:SubW]] <= run_q[15:0];
    span_rd_q <= span_q[pos_q[15:BitW+SubW]];
  end

  // read address selection, the scan reads one word ahead
  always_comb begin
    raddr = wi_q;
    if (state_q == ST_IDLE) raddr = tgt_in[15:BitW];
    if (state_q == ST_SCAN) raddr = wi_q + 1'b1;
  end

  // word read masked by target bit offset on the first word, and below the hit bit on the rank's hit word
  always_comb begin
    masked = rdata;
    if (first_q) masked = rdata & ({WordBits{1'b1}} << tgt_q[BitW-1:0]);
    if (state_q == ST_RANK_WORDS && !rd_pend_q && rk_q == pos_q[BitW+SubW-1:BitW])
      masked = rdata & ~({WordBits{1'b1}} << pos_q[BitW-1:0]);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && req == REQ_SEEK) begin
          if (last_v_q && tgt_in <= last_q) state_d = ST_RANK_SPAN;
          else if ((WAddrW+1)'(tgt_in[15:BitW]) >= limit) state_d = ST_OUT;
          else state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (masked != '0) state_d = ST_RANK_SPAN;
        else if ((WAddrW+1)'(wi_q) + 1'b1 >= limit) state_d = ST_OUT;
      end
      ST_RANK_SPAN:  state_d = ST_RANK_WORDS;
      ST_RANK_WORDS: begin
        if (!rd_pend_q && rk_q == pos_q[BitW+SubW-1:BitW]) state_d = ST_OUT;
      end
      ST_OUT:        state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_id_q <= '0; rank_base_q <= '0; lp_q <= '0;
      run_q <= '0; last_v_q <= 1'b0; out_v_q <= 1'b0; last_q <= '0;
      first_q <= 1'b0; rd_pend_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_BLOCK_ID) block_id_q <= cfg_data_i[15:0];
        else rank_base_q <= cfg_data_i;
      end
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (acc) begin
          case (req)
            REQ_RESTART: begin
              lp_q <= '0; run_q <= '0; last_v_q <= 1'b0;
              found_q <= 1'b0; out_doc_q <= {block_id_q, 16'd0};
              out_rank_q <= rank_base_q; out_v_q <= 1'b1;
            end
            REQ_LOAD: begin
              found_q <= 1'b0; out_doc_q <= {block_id_q, 16'd0};
              if (ram_we) begin
                lp_q <= lp_q + 1'b1;
                run_q <= run_q + 17'(pop_word(wdata_in));
                out_rank_q <= rank_base_q + 32'(run_q + 17'(pop_word(wdata_in)));
              end else out_rank_q <= rank_base_q + 32'(run_q);
              out_v_q <= 1'b1;
            end
            REQ_SEEK: begin
              tgt_q <= tgt_in; wi_q <= tgt_in[15:BitW]; first_q <= 1'b1;
              rd_pend_q <= 1'b0;
              if (last_v_q && tgt_in <= last_q) begin
                // rank recompute
                pos_q <= last_q; found_q <= 1'b1;
              end else if ((WAddrW+1)'(tgt_in[15:BitW]) >= limit) begin
                found_q <= 1'b0;
              end
            end
            default: begin
              found_q <= 1'b0; out_doc_q <= {block_id_q, 16'd0};
              out_rank_q <= rank_base_q + 32'(run_q); out_v_q <= 1'b1;
            end
          endcase
        end
        ST_SCAN: begin
          // rdata holds word wi_q
          first_q <= 1'b0;
          if (masked != '0) begin
            pos_q <= {wi_q, low_zeros(masked)}; found_q <= 1'b1;
            last_q <= {wi_q, low_zeros(masked)}; last_v_q <= 1'b1;
          end else if ((WAddrW+1)'(wi_q) + 1'b1 >= limit) begin
            found_q <= 1'b0;
          end else begin
            wi_q <= wi_q + 1'b1;
          end
        end
        ST_RANK_SPAN: begin
          // span table read now in flight; start word reads at span start
          first_q <= 1'b0;
          wi_q <= {pos_q[15:BitW+SubW], {SubW{1'b0}}};
          rk_q <= '0; rd_pend_q <= 1'b1;
        end
        ST_RANK_WORDS: begin
          if (rd_pend_q) begin
            if (rk_q == '0) cnt_q <= 17'(span_rd_q);
            rd_pend_q <= 1'b0;
          end else begin
            cnt_q <= cnt_q + 17'(pop_word(masked));
            if (rk_q != pos_q[BitW+SubW-1:BitW]) begin
              rk_q <= rk_q + 1'b1; wi_q <= wi_q + 1'b1; rd_pend_q <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          out_doc_q  <= {block_id_q, found_q ? pos_q : 16'd0};
          out_rank_q <= rank_base_q + 32'(found_q ? cnt_q : run_q);
          out_v_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_rank_q, out_doc_q};
  assign m_axis_tuser  = found_q;

  // the input side is closed while a seek runs
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !s_axis_tready) else $error("ready during seek");
  // load pointer never exceeds the block
  a_lp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lp_q <= (WAddrW+1)'(BlockWords)) else $error("load pointer overrun");
  // cursor valid only after a found result
  a_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(last_v_q) |-> found_q) else $error("cursor without hit");

endmodule

// ===== tb/sv/dense_bitmap_next_set_bit_rank_tb.sv =====
// dense_bitmap_next_set_bit_rank_tb: loads bitmaps, seeks and checks found/doc id/rank
// against an in-bench bitmap predictor; depends on dbr_pkg and the block itself
`timescale 1ns / 1ps

module dense_bitmap_next_set_bit_rank_tb;
  import dbr_pkg::*;

  typedef struct packed {
    logic        found;
    logic [31:0] doc_id;
    logic [31:0] rank;
  } seek_res_t;

  // bitmap predictor plus queue of expected result beats
  class rank_scoreboard;
    logic [63:0] words[BlockWords];
    logic [15:0] span_cnt[SpanCount];
    int unsigned load_ptr;
    logic [16:0] load_cnt;
    logic [16:0] last_pos;
    bit          last_ok;
    logic [15:0] blk_id;
    logic [31:0] base;
    seek_res_t   pending[$];
    int          errors;
    int          checked;

    function void clear();
      load_ptr = 0; load_cnt = '0; last_pos = '0; last_ok = 0;
      blk_id = '0; base = '0; pending.delete(); errors = 0; checked = 0;
    endfunction

    function int unsigned set_before(int unsigned pos);
      int unsigned w, b, cnt;
      w = pos / WordBits;
      b = pos % WordBits;
      cnt = span_cnt[w / SpanWords];
      for (int unsigned i = (w / SpanWords) * SpanWords; i < w; i++)
        cnt += $countones(words[i]);
      if (b != 0) cnt += $countones(words[w] & ((64'd1 << b) - 64'd1));
      return cnt;
    endfunction

    function void push(bit f, int unsigned pos, int unsigned r);
      seek_res_t e;
      e.found  = f;
      e.doc_id = {blk_id, 16'd0} + (f ? pos : 0);
      e.rank   = base + r;
      pending.push_back(e);
    endfunction

    // note an accepted input beat
    function void note_input(req_e req, logic [63:0] wd, logic [15:0] tgt);
      int unsigned wi, pos;
      bit hit;
      logic [63:0] left;
      case (req)
        REQ_RESTART: begin
          load_ptr = 0; load_cnt = '0; last_ok = 0;
          push(0, 0, 0);
        end
        REQ_LOAD: begin
          if (load_ptr < BlockWords) begin
            if (load_ptr % SpanWords == 0) span_cnt[load_ptr / SpanWords] = load_cnt[15:0];
            words[load_ptr] = wd;
            load_cnt = load_cnt + $countones(wd);
            load_ptr++;
          end
          push(0, 0, load_cnt);
        end
        REQ_SEEK: begin
          if (last_ok && tgt <= last_pos) begin
            push(1, last_pos, set_before(last_pos));
            return;
          end
          wi = tgt / WordBits;
          hit = 0;
          if (wi < load_ptr) begin
            left = words[wi] >> (tgt % WordBits);
            if (left != 0) begin
              hit = 1; pos = tgt;
              while (!left[0]) begin left = left >> 1; pos++; end
            end else begin
              for (int unsigned i = wi + 1; i < load_ptr && !hit; i++)
                if (words[i] != 0) begin
                  hit = 1; pos = i * WordBits;
                  while (!words[i][pos % WordBits]) pos++;
                end
            end
          end
          if (hit) begin
            last_pos = pos; last_ok = 1;
            push(1, pos, set_before(pos));
          end else push(0, 0, load_cnt);
        end
        default: push(0, 0, load_cnt);
      endcase
    endfunction

    // check a result beat against the oldest expectation
    task check_result(seek_res_t got);
      seek_res_t e;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch("result beat with nothing expected", 0, got.doc_id);
        return;
      end
      e = pending.pop_front();
      if (got.found !== e.found) report_mismatch("found", e.found, got.found);
      if (got.doc_id !== e.doc_id) report_mismatch("doc_id", e.doc_id, got.doc_id);
      if (got.rank !== e.rank) report_mismatch("rank", e.rank, got.rank);
    endtask

    task report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
      errors++;
      if (errors <= 40)
        $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $time);
    endtask
  endclass

  localparam int StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;   // word_data[63:0], target[79:64]
  logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // doc_id[31:0], rank[63:32]
  logic        m_axis_tuser;        // found
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  rank_scoreboard sb;
  bit  quiet_phase;
  int  idle_cycles;
  int  n_seeks;

  dense_bitmap_next_set_bit_rank u_dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: random stalls, check each beat
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result('{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]});
  end

  initial begin
    int burst;
    forever begin
      @(posedge clk_i);
      if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 7);
        m_axis_tready <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog: cycles with no beat accepted anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("timeout: no beat for %0d cycles", StallLimit);
      $display("dense_bitmap_next_set_bit_rank verification failed");
      $finish;
    end
  end

  // send one request beat, with an optional random gap first; valid stays up
  // after the beat until the next gap or the drain
  task automatic send(req_e req, logic [63:0] wd, logic [15:0] tgt);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {tgt, wd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(req, wd, tgt);
    if (req == REQ_SEEK) n_seeks++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_BLOCK_ID) sb.blk_id = val[15:0];
    else sb.base = val;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_word(int density);
    logic [63:0] w;
    w = {$urandom, $urandom};
    case (density)
      0: w = '0;
      1: w = w & {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      2: w = '1;
      default: ;
    endcase
    return w;
  endfunction

  // restart, load n words of random density, then several seeks and sometimes an unknown request
  task automatic bitmap_run(int nwords, int nseeks);
    int dens;
    int unsigned span;
    logic [15:0] t;
    send(REQ_RESTART, {$urandom, $urandom}, 16'($urandom));
    dens = $urandom_range(0, 4);
    for (int i = 0; i < nwords; i++)
      send(REQ_LOAD, ($urandom_range(0, 3) == 0) ? '0 : rand_word(dens), 16'($urandom));
    span = (nwords + 2) * WordBits;
    if (span > 65536) span = 65536;
    t = 16'($urandom_range(0, span - 1));
    for (int i = 0; i < nseeks; i++) begin
      case ($urandom_range(0, 5))
        0: t = 16'($urandom);
        1: t = t;
        2: t = t - 16'($urandom_range(0, 40));
        default: t = t + 16'($urandom_range(1, 150));
      endcase
      send(REQ_SEEK, {$urandom, $urandom}, t);
    end
    if ($urandom_range(0, 4) == 0) send(REQ_NONE, {$urandom, $urandom}, 16'($urandom));
  endtask

  initial begin
    sb = new();
    sb.clear();
    quiet_phase = 0;
    idle_cycles = 0;
    n_seeks = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: register extremes, every request kind, edge positions
    write_reg(CFG_BLOCK_ID, 32'hFFFF);
    write_reg(CFG_RANK_BASE, 32'hFFFF_FFF0);
    send(REQ_SEEK, '0, 16'd0);              // seek with nothing loaded
    send(REQ_LOAD, 64'h8000_0000_0000_0001, 16'hFFFF);
    send(REQ_LOAD, '0, '0);
    send(REQ_LOAD, '1, '0);
    send(REQ_SEEK, '0, 16'd0);              // hit at bit 0
    send(REQ_SEEK, '0, 16'd0);              // repeat seek
    send(REQ_SEEK, '1, 16'd1);              // hit at bit 63
    send(REQ_SEEK, '0, 16'd64);             // skip a zero word
    send(REQ_SEEK, '0, 16'd191);            // last loaded bit
    send(REQ_SEEK, '0, 16'd192);            // past loaded words
    send(REQ_SEEK, '0, 16'hFFFF);
    send(REQ_NONE, '1, 16'hFFFF);
    send(REQ_RESTART, '1, 16'hFFFF);
    send(REQ_SEEK, '0, 16'd0);              // cursor cleared
    drain();
    write_reg(CFG_BLOCK_ID, 32'h0);
    write_reg(CFG_RANK_BASE, 32'h0);

    // full block, then loads past the end and seeks near the top
    send(REQ_RESTART, '0, '0);
    for (int i = 0; i < BlockWords; i++)
      send(REQ_LOAD, (i % 97 == 5 || i == BlockWords - 1) ? rand_word(3) : '0, '0);
    send(REQ_LOAD, '1, '0);
    send(REQ_SEEK, '0, 16'd0);
    send(REQ_SEEK, '0, 16'd400);
    send(REQ_SEEK, '0, 16'hFFC0);
    send(REQ_SEEK, '0, 16'hFFFF);
    drain();

    // random phases with different register settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_BLOCK_ID, (ph == 0) ? 32'hFFFF : 32'($urandom_range(0, 65535)));
      write_reg(CFG_RANK_BASE, (ph == 1) ? 32'hFFFF_FFFF : $urandom);
      if (ph == 4) quiet_phase = 1;
      for (int r = 0; r < 3; r++)
        bitmap_run($urandom_range(1, (r == 0) ? 40 : 20), $urandom_range(8, 25));
      drain();
    end

    $display("covered full 1024-word block, %0d seeks, %0d results checked",
             n_seeks, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("dense_bitmap_next_set_bit_rank verification clean");
    else
      $display("dense_bitmap_next_set_bit_rank verification failed");
    $finish;
  end
endmodule
